// ===== rtl/core/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types, constants and the symbol mapping table of the utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 3;
   localparam int LEFT_W = 2;

   localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HYPHEN     = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             bad_lead;
      logic             truncated;
   } dec_result_type;

   function automatic logic [BYTE_W-1:0] map_char(input logic [CP_W-1:0] cp);
      logic [BYTE_W-1:0] ch;
      if (cp[CP_W-1:BYTE_W] == '0) begin
         ch = cp[BYTE_W-1:0];
      end else begin
         case (cp)
            21'h002010, 21'h002011:             ch = CHAR_HYPHEN;
            21'h002012, 21'h002013, 21'h002014: ch = CHAR_UNDERSCORE;
            21'h002015: ch = 8'd151;
            21'h002018: ch = 8'd145;
            21'h002019: ch = 8'd146;
            21'h00201C: ch = 8'd147;
            21'h00201D: ch = 8'd148;
            21'h002020: ch = 8'd134;
            21'h002021: ch = 8'd135;
            21'h002022: ch = 8'd149;
            21'h002030: ch = 8'd137;
            21'h0020AC: ch = 8'd128;
            21'h002122: ch = 8'd153;
            default:    ch = CHAR_SPACE;
         endcase
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/utf8d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_decode
// sequence state and byte decode: lead length, continuation shift, early end
// ----------------------------------------------------------------------------
module utf8d_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [utf8d_pkg::BYTE_W-1:0]      in_byte,
   input  logic                              end_of_string,
   output logic                              emit,
   output utf8d_pkg::dec_result_type         result
);
   import utf8d_pkg::*;

   logic [CP_W-1:0]   acc_ff, acc_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [CP_W-1:0]   padded;
   logic              in_seq;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         left_ff <= '0;
         plen_ff <= '0;
      end else if (step) begin
         acc_ff  <= acc_in;
         left_ff <= left_in;
         plen_ff <= plen_in;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      left_in = left_ff;
      plen_in = plen_ff;
      emit    = 1'b0;
      in_seq  = 1'b0;
      padded  = '0;
      result  = '{code_point: {13'd0, in_byte}, seq_length: LEN_ONE,
                  bad_lead: 1'b0, truncated: 1'b0};
      if (left_ff == '0) begin
         priority if (in_byte[7] == 1'b0) begin
            emit = 1'b1;
         end else if (in_byte[7:5] == 3'b110) begin
            acc_in  = {16'd0, in_byte[4:0]};
            plen_in = LEN_TWO;
            left_in = 2'd1;
            in_seq  = 1'b1;
         end else if (in_byte[7:4] == 4'b1110) begin
            acc_in  = {17'd0, in_byte[3:0]};
            plen_in = LEN_THREE;
            left_in = 2'd2;
            in_seq  = 1'b1;
         end else if (in_byte[7:3] == 5'b11110) begin
            acc_in  = {18'd0, in_byte[2:0]};
            plen_in = LEN_FOUR;
            left_in = 2'd3;
            in_seq  = 1'b1;
         end else begin
            emit            = 1'b1;
            result.bad_lead = 1'b1;
         end
      end else begin
         acc_in  = {acc_ff[CP_W-7:0], in_byte[5:0]};
         left_in = left_ff - 2'd1;
         if (left_in == '0) begin
            emit              = 1'b1;
            result.code_point = acc_in;
            result.seq_length = plen_ff;
            acc_in            = '0;
            plen_in           = '0;
         end else begin
            in_seq = 1'b1;
         end
      end
      if (in_seq && end_of_string) begin
         // missing continuation bytes count as zero
         unique case (left_in)
            2'd1:    padded = {acc_in[CP_W-7:0], 6'd0};
            2'd2:    padded = {acc_in[CP_W-13:0], 12'd0};
            2'd3:    padded = {acc_in[CP_W-19:0], 18'd0};
            default: padded = acc_in;
         endcase
         emit              = 1'b1;
         result.code_point = padded;
         result.seq_length = plen_in;
         result.truncated  = 1'b1;
         acc_in            = '0;
         left_in           = '0;
         plen_in           = '0;
      end
   end

endmodule

// ===== rtl/core/utf8d_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_map
// maps a code point to the 8-bit charset and flags wide characters
// ----------------------------------------------------------------------------
module utf8d_map (
   input  logic [utf8d_pkg::CP_W-1:0]   code_point,
   output logic [utf8d_pkg::BYTE_W-1:0] mapped_char,
   output logic                         wide_char
);
   import utf8d_pkg::*;

   assign mapped_char = map_char(code_point);
   assign wide_char   = (code_point[CP_W-1:BYTE_W] != '0);

endmodule

// ===== rtl/core/utf8_decode_to_8bit_charset_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_to_8bit_charset_core
// utf-8 byte stream decoder with mapping of code points to an 8-bit charset
// ----------------------------------------------------------------------------
// path: an accepted byte is held in the input register, then decoded, and a byte that
//   ends a character (or the string) loads the result register, which drives rsp_tvalid
// throughput: one byte per cycle unless a held result waits on rsp_tready, set by the
//   input register feeding one decode pass into the result register
// reset: synchronous, clears both stage valids and the sequence state
// ----------------------------------------------------------------------------
module utf8_decode_to_8bit_charset_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // code_point[20:0], mapped_char[28:21], seq_length[31:29]
   output logic [2:0]  rsp_tuser    // bad_lead[0], wide_char[1], truncated[2]
);
   import utf8d_pkg::*;

   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [31:0]       rsp_data_ff;
   logic [2:0]        rsp_user_ff;
   logic              advance;
   logic              emit;
   dec_result_type    dec;
   logic [BYTE_W-1:0] mapped;
   logic              wide;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign rsp_vld_in = (advance && emit) || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && emit) begin
         rsp_data_ff <= {dec.seq_length, mapped, dec.code_point};
         rsp_user_ff <= {dec.truncated, wide, dec.bad_lead};
      end
   end

   utf8d_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .in_byte       (in_byte_ff),
      .end_of_string (in_last_ff),
      .emit          (emit),
      .result        (dec)
   );

   utf8d_map u_map (
      .code_point  (dec.code_point),
      .mapped_char (mapped),
      .wide_char   (wide)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
